>>> hdl/efd_pkg.sv
// ============================================================================
// efd_pkg
// Shared widths, register indexes and error-share arithmetic for the
// error-diffusion dither core.
// ============================================================================
package efd_pkg;

  localparam int PIX_W       = 8;   // gray and binary pixel width
  localparam int ERR_W       = 9;   // signed error and stored error sums
  localparam int SUM_W       = 11;  // signed corrected value
  localparam int PROD_W      = 13;  // signed error times weight
  localparam int WIDTH_REG_W = 13;  // line_width register
  localparam int THR_W       = 8;   // threshold register
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 1'd1;

  localparam logic [WIDTH_REG_W-1:0] LINE_WIDTH_RESET = 13'd640;
  localparam logic [THR_W-1:0]       THRESHOLD_RESET  = 8'd128;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

  // Diffusion weights, in sixteenths
  localparam logic [3:0] WGT_RIGHT       = 4'd7;
  localparam logic [3:0] WGT_BELOW_LEFT  = 4'd3;
  localparam logic [3:0] WGT_BELOW       = 4'd5;
  localparam logic [3:0] WGT_BELOW_RIGHT = 4'd1;

  typedef logic signed [ERR_W-1:0] err_t;

  // err * weight / 16, truncated toward zero
  function automatic err_t share16(input err_t err, input logic [3:0] weight);
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] quot;
    prod   = PROD_W'(err) * PROD_W'(weight);
    biased = prod + (prod[PROD_W-1] ? 13'sd15 : 13'sd0);
    quot   = biased >>> 4;
    return $signed(quot[ERR_W-1:0]);
  endfunction

endpackage

>>> hdl/efd_stream_if.sv
// ============================================================================
// efd_stream_if
// Valid/ready channels for gray pixels in and binary pixels out.
// ============================================================================
interface efd_pixel_if;
  import efd_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] gray_pixel;
  logic             start_of_frame;

  modport source (output valid, gray_pixel, start_of_frame, input ready);
  modport sink   (input valid, gray_pixel, start_of_frame, output ready);
endinterface

interface efd_result_if;
  import efd_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] binary_pixel;
  logic             end_of_row;

  modport source (output valid, binary_pixel, end_of_row, input ready);
  modport sink   (input valid, binary_pixel, end_of_row, output ready);
endinterface

>>> hdl/error_diffusion_dither_core.sv
// ============================================================================
// error_diffusion_dither_core
// Floyd-Steinberg binarizer for a raster-order 8-bit gray pixel stream.
// ============================================================================
//
//  channel   role    beat contents
//  --------  ------  ----------------------------------------------
//  pix_in    sink    gray_pixel, start_of_frame
//  res_out   source  binary_pixel (0 or 255), end_of_row
//  cfg_*     write   cfg_index 0: line_width, 1: threshold
//
//  One pixel per clock sustained while res_out is ready; a beat accepted on
//  pix_in passes the input register, then the correction logic, then the
//  result register before it shows on res_out. The line store is one memory
//  of MAX_WIDTH entries with one write and one registered read per cycle.
//  Reset is synchronous; there is no clearing pass, since the first row of a
//  frame never reads the line store.
//  A stall on res_out holds the result register and the input register;
//  pix_in keeps taking beats while either register has room.
//
module error_diffusion_dither_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  efd_pixel_if.sink                       pix_in,
  efd_result_if.source                    res_out,
  input  logic                            cfg_write,
  input  logic [efd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [efd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import efd_pkg::*;

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CNT_W  = $clog2(MAX_WIDTH + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0] line_width;
  logic [THR_W-1:0]       threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
      threshold  <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LINE_WIDTH: line_width <= cfg_data[WIDTH_REG_W-1:0];
        REG_THRESHOLD:  threshold  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, anything above the store depth clips to it
  logic [CNT_W-1:0] eff_width;
  always_comb begin
    if (line_width == '0) begin
      eff_width = CNT_W'(1);
    end else if (32'(line_width) > MAX_WIDTH) begin
      eff_width = CNT_W'(MAX_WIDTH);
    end else begin
      eff_width = CNT_W'(line_width);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic out_valid;
  logic advance;   // input register moves into the result register
  logic in_fire;

  assign advance      = s1_valid && (!out_valid || res_out.ready);
  assign pix_in.ready = !s1_valid || advance;
  assign in_fire      = pix_in.valid && pix_in.ready;

  // --------------------------------------------------------------------------
  // Front position tracking: column and first-row flag depend only on the
  // width and start_of_frame, so settle them at the accept edge.
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] column;
  logic              first_row;
  logic [ADDR_W-1:0] col_in;
  logic              first_in;
  logic              last_in;

  always_comb begin
    col_in   = pix_in.start_of_frame ? '0 : column;
    first_in = pix_in.start_of_frame ? 1'b1 : first_row;
    last_in  = (CNT_W'(col_in) + CNT_W'(1)) >= eff_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      first_row <= 1'b1;
    end else if (in_fire) begin
      column    <= last_in ? '0 : ADDR_W'(col_in + 1'b1);
      first_row <= last_in ? 1'b0 : first_in;
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0]  s1_gray;
  logic              s1_sof;
  logic              s1_first;
  logic              s1_last;
  logic [ADDR_W-1:0] s1_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_gray  <= pix_in.gray_pixel;
      s1_sof   <= pix_in.start_of_frame;
      s1_first <= first_in;
      s1_last  <= last_in;
      s1_col   <= col_in;
    end
  end

  // --------------------------------------------------------------------------
  // Correction and quantization for the pixel in the input register
  // --------------------------------------------------------------------------
  err_t right_share;
  err_t pending_below_left;
  err_t pending_below;

  err_t mem_q;
  logic fwd_valid;
  err_t fwd_data;

  err_t                    rs_use;
  err_t                    pbl_use;
  err_t                    pb_use;
  err_t                    line_use;
  logic signed [SUM_W-1:0] gray_ext;
  logic signed [SUM_W-1:0] thr_ext;
  logic signed [SUM_W-1:0] corrected;
  logic signed [SUM_W-1:0] out_ext;
  logic signed [SUM_W-1:0] err_wide;
  logic                    is_white;
  err_t                    err;
  err_t                    bl_sum;      // final sum for the entry below-left
  err_t                    below_sum;   // running sum for the entry below
  err_t                    br_share;
  err_t                    right_new;

  always_comb begin
    // start of frame clears the carried shares before this pixel
    rs_use   = s1_sof ? '0 : right_share;
    pbl_use  = s1_sof ? '0 : pending_below_left;
    pb_use   = s1_sof ? '0 : pending_below;
    // the first row never looks at the line store
    line_use = s1_first ? '0 : (fwd_valid ? fwd_data : mem_q);

    gray_ext  = $signed({{(SUM_W-PIX_W){1'b0}}, s1_gray});
    thr_ext   = $signed({{(SUM_W-THR_W){1'b0}}, threshold});
    corrected = gray_ext + SUM_W'(rs_use) + SUM_W'(line_use);
    is_white  = corrected >= thr_ext;
    out_ext   = $signed({{(SUM_W-PIX_W){1'b0}}, (is_white ? PIX_WHITE : PIX_BLACK)});
    err_wide  = corrected - out_ext;
    err       = $signed(err_wide[ERR_W-1:0]);

    bl_sum    = pbl_use + share16(err, WGT_BELOW_LEFT);
    below_sum = pb_use + share16(err, WGT_BELOW);
    br_share  = share16(err, WGT_BELOW_RIGHT);
    right_new = share16(err, WGT_RIGHT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_share        <= '0;
      pending_below_left <= '0;
      pending_below      <= '0;
    end else if (advance) begin
      if (s1_last) begin
        right_share        <= '0;
        pending_below_left <= '0;
        pending_below      <= '0;
      end else begin
        right_share        <= right_new;
        pending_below_left <= below_sum;
        pending_below      <= br_share;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line store. A pixel finishes the entry below-left of it; the last pixel
  // of a row also finishes the entry below it, and that second write is held
  // to the cycle after, when the next pixel (column zero) writes nothing.
  // --------------------------------------------------------------------------
  err_t line_mem [MAX_WIDTH];

  logic              defer_valid;
  logic [ADDR_W-1:0] defer_addr;
  err_t              defer_data;
  logic              wr_bl;

  assign wr_bl = advance && (s1_col != '0);

  always_ff @(posedge clk) begin
    if (wr_bl) begin
      line_mem[ADDR_W'(s1_col - 1'b1)] <= bl_sum;
    end else if (defer_valid) begin
      line_mem[defer_addr] <= defer_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_q <= line_mem[col_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      defer_valid <= 1'b0;
    end else begin
      defer_valid <= advance && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      defer_addr <= s1_col;
      defer_data <= below_sum;
    end
  end

  // Bypass writes that land at or after the read edge; newest wins
  logic fwd_hit;
  err_t fwd_next;

  always_comb begin
    fwd_hit  = 1'b0;
    fwd_next = defer_data;
    if (wr_bl && (ADDR_W'(s1_col - 1'b1) == col_in)) begin
      fwd_hit  = 1'b1;
      fwd_next = bl_sum;
    end else if (advance && s1_last && (s1_col == col_in)) begin
      fwd_hit  = 1'b1;
      fwd_next = below_sum;
    end else if (defer_valid && (defer_addr == col_in)) begin
      fwd_hit  = 1'b1;
      fwd_next = defer_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (in_fire) begin
      fwd_valid <= fwd_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_data <= fwd_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] out_pixel;
  logic             out_eor;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pixel <= is_white ? PIX_WHITE : PIX_BLACK;
      out_eor   <= s1_last;
    end
  end

  assign res_out.valid        = out_valid;
  assign res_out.binary_pixel = out_pixel;
  assign res_out.end_of_row   = out_eor;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The parked row-end write never meets a below-left write
  a_write_port_free: assert property (@(posedge clk) disable iff (rst)
    defer_valid |-> !wr_bl)
    else $error("line store write collision");

  a_binary_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_pixel == PIX_WHITE) || (out_pixel == PIX_BLACK))
    else $error("binary pixel is neither black nor white");

  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced pixel missing from result register");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> s1_valid && out_valid && !res_out.ready)
    else $error("input stalled with room in the pipeline");

endmodule

>>> sim/error_diffusion_dither_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// error_diffusion_dither_core_tb
// Self-checking bench for the Floyd-Steinberg binarizer. Gray pixel beats
// go in through a valid/ready channel. Each accepted beat runs through a
// local error-diffusion predictor. Every result beat is checked field by
// field against the oldest prediction. Both channels idle at random.
// ============================================================================
module error_diffusion_dither_core_tb;
  import efd_pkg::*;

  localparam int MAX_W            = 4096;
  localparam int LONG_HOLD_AT     = 500;  // results seen before the long output stall
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int MAX_PRINTS       = 40;
  localparam int NUM_PHASES       = 13;

  typedef struct packed {
    logic [PIX_W-1:0] gray_pixel;
    logic             start_of_frame;
  } gray_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] binary_pixel;
    logic             end_of_row;
  } dither_beat_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  efd_pixel_if  pix_bus ();
  efd_result_if res_bus ();

  error_diffusion_dither_core #(
    .MAX_WIDTH (MAX_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_bus),
    .res_out   (res_bus),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Stimulus and expectation stores
  // --------------------------------------------------------------------------
  gray_beat_t   pixel_q[$];          // beats waiting for the driver
  dither_beat_t dither_expect_q[$];  // predicted results, oldest first

  int mismatch_cnt = 0;
  int sent_cnt     = 0;
  int checked_cnt  = 0;
  int reg_writes   = 0;

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the registers, the line store and the
  // running error shares of the current row.
  // --------------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0] cur_width  = LINE_WIDTH_RESET;
  logic [THR_W-1:0]       cur_thresh = THRESHOLD_RESET;
  err_t                   line_err [MAX_W];
  err_t                   carry_right   = '0;
  err_t                   held_below_lt = '0;
  err_t                   held_below    = '0;
  logic [11:0]            col_pos       = '0;
  logic                   top_row       = 1'b1;

  // Set when a width write widens the row: the next beat must open a frame so
  // that no later row reads line-store entries that were never written.
  logic need_sof = 1'b0;

  // Width 0 behaves as 1, anything past the line store is clipped to it.
  function automatic int usable_width(input logic [WIDTH_REG_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_W) return MAX_W;
    return int'(w);
  endfunction

  // Run one accepted gray beat through the diffusion and queue its result.
  task automatic diffuse_pixel(input logic [PIX_W-1:0] gray, input logic sof);
    int           w;
    int           c;
    int           corr;
    int           err;
    dither_beat_t beat;
    w = usable_width(cur_width);
    if (sof) begin
      col_pos       = '0;
      carry_right   = '0;
      held_below_lt = '0;
      held_below    = '0;
      top_row       = 1'b1;
    end
    c               = int'(col_pos);
    beat.end_of_row = (c + 1 >= w);

    // Left share always counts; the row above only after the first row.
    corr = int'(gray) + carry_right;
    if (!top_row) corr += line_err[c];

    beat.binary_pixel = (corr >= int'(cur_thresh)) ? PIX_WHITE : PIX_BLACK;
    err               = corr - int'(beat.binary_pixel);

    // Shares truncate toward zero; the below-left share has no home at col 0.
    if (c > 0) line_err[c-1] = err_t'(held_below_lt + err * 3 / 16);
    if (beat.end_of_row) begin
      // Close the row: the below share lands directly, below-right is dropped.
      line_err[c]   = err_t'(held_below + err * 5 / 16);
      col_pos       = '0;
      carry_right   = '0;
      held_below_lt = '0;
      held_below    = '0;
      top_row       = 1'b0;
    end else begin
      held_below_lt = err_t'(held_below + err * 5 / 16);
      held_below    = err_t'(err / 16);
      carry_right   = err_t'(err * 7 / 16);
      col_pos       = 12'(c + 1);
    end
    dither_expect_q.push_back(beat);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_cnt < MAX_PRINTS)
      $display("%0t ns: mismatch on result %0d: %s got %0d, expected %0d",
               $time, checked_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // Mostly short gaps, some long ones, and bursts with no gap at all.
  function automatic int draw_gap(inout int streak);
    int r;
    if (streak > 0) begin
      streak--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 4) begin
      streak = $urandom_range(40, 160);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive every block input to a known value before the first edge.
  initial begin
    pix_bus.valid          = 1'b0;
    pix_bus.gray_pixel     = '0;
    pix_bus.start_of_frame = 1'b0;
    res_bus.ready          = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Driver: offer queued beats on pix_in, predict on each accepted beat.
  // Fields are only touched when a new beat is put up, so they hold steady
  // through any stall.
  // --------------------------------------------------------------------------
  int         send_gap    = 0;
  int         send_streak = 0;
  gray_beat_t next_px;

  always @(posedge clk) begin
    if (rst) begin
      pix_bus.valid          <= 1'b0;
      pix_bus.gray_pixel     <= '0;
      pix_bus.start_of_frame <= 1'b0;
      send_gap = 0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        diffuse_pixel(pix_bus.gray_pixel, pix_bus.start_of_frame);
        sent_cnt++;
      end
      if (!pix_bus.valid || pix_bus.ready) begin
        if (send_gap == 0 && pixel_q.size() != 0) begin
          next_px = pixel_q.pop_front();
          pix_bus.valid          <= 1'b1;
          pix_bus.gray_pixel     <= next_px.gray_pixel;
          pix_bus.start_of_frame <= next_px.start_of_frame;
          send_gap = draw_gap(send_streak);
        end else begin
          if (send_gap > 0) send_gap--;
          pix_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check result beats against the oldest prediction and throttle
  // ready. Once LONG_HOLD_AT results are in, hold ready low for a long
  // stretch so that both internal registers fill and pix_in backs up.
  // --------------------------------------------------------------------------
  int           stall_left     = 0;
  int           stall_streak   = 0;
  logic         long_hold_done = 1'b0;
  dither_beat_t want;

  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (dither_expect_q.size() == 0) begin
          report_mismatch("unexpected beat, binary_pixel", res_bus.binary_pixel, -1);
        end else begin
          want = dither_expect_q.pop_front();
          if (res_bus.binary_pixel !== want.binary_pixel)
            report_mismatch("binary_pixel", res_bus.binary_pixel, want.binary_pixel);
          if (res_bus.end_of_row !== want.end_of_row)
            report_mismatch("end_of_row", res_bus.end_of_row, want.end_of_row);
        end
        checked_cnt++;
      end
      if (!long_hold_done && checked_cnt >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD_CYCLES;
      end else if (stall_left == 0 && res_bus.ready) begin
        stall_left = draw_gap(stall_streak);
      end
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing helpers
  // --------------------------------------------------------------------------
  task automatic push_beat(input int gray, input logic sof);
    gray_beat_t b;
    b.gray_pixel     = PIX_W'(gray);
    b.start_of_frame = sof;
    if (sof) need_sof = 1'b0;
    pixel_q.push_back(b);
  endtask

  // Hold the sender until every queued beat went in and every result came out.
  task automatic wait_drain();
    do @(negedge clk);
    while (pixel_q.size() != 0 || pix_bus.valid || dither_expect_q.size() != 0);
  endtask

  // Write one register while the block is idle and update the local copy.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    if (idx == REG_LINE_WIDTH) begin
      if (usable_width(WIDTH_REG_W'(value)) > usable_width(cur_width)) need_sof = 1'b1;
      cur_width = WIDTH_REG_W'(value);
    end else begin
      cur_thresh = THR_W'(value);
    end
    reg_writes++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Gray content styles: noise, flat field, black/white, near threshold, ramp.
  function automatic int pick_gray(input int mode, input int level, input int idx);
    int v;
    case (mode)
      0: v = $urandom_range(255);
      1: v = level;
      2: v = $urandom_range(1) ? 255 : 0;
      3: begin
        v = int'(cur_thresh) + $urandom_range(16) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      default: v = (level + idx * 7) & 255;
    endcase
    return v;
  endfunction

  // Mostly whole frames with random content; a few stray frame starts mixed in.
  task automatic random_phase(input int n);
    int   w;
    int   frame_left;
    int   mode;
    int   level;
    int   idx;
    int   k;
    logic sof;
    w          = usable_width(cur_width);
    mode       = $urandom_range(4);
    level      = $urandom_range(255);
    idx        = 0;
    frame_left = (need_sof || $urandom_range(1)) ? 0 : $urandom_range(1, 4 * w);
    @(negedge clk);
    for (k = 0; k < n; k++) begin
      sof = 1'b0;
      if (frame_left <= 0) begin
        sof        = 1'b1;
        frame_left = w * $urandom_range(1, 4) + $urandom_range(0, w - 1);
        mode       = $urandom_range(4);
        level      = $urandom_range(255);
        idx        = 0;
      end else if ($urandom_range(59) == 0) begin
        sof = 1'b1;
      end
      push_beat(pick_gray(mode, level, idx), sof);
      frame_left--;
      idx++;
    end
    wait_drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  int phase_width  [NUM_PHASES] = '{8, 1, 16, 5, 37, 2, 11, 3, 640, 24, 7, 4096, 6};
  int phase_thresh [NUM_PHASES] = '{128, 100, 0, 255, 200, 50, 128, 1, 128, 77, 128, 128, 160};
  int phase_items  [NUM_PHASES] = '{120, 40, 60, 60, 100, 60, 120, 60, 80, 120, 100, 50, 80};

  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: extremes of gray on the first row of a fresh frame.
    @(negedge clk);
    push_beat(255, 1'b1);
    push_beat(0, 1'b0);
    push_beat(128, 1'b0);
    push_beat(127, 1'b0);
    push_beat(129, 1'b0);
    wait_drain();

    // Width 0 acts as 1, and shrinking mid-row ends the current row at once.
    write_reg(REG_LINE_WIDTH, 0);
    @(negedge clk);
    push_beat(200, 1'b0);
    push_beat(60, 1'b0);
    push_beat(255, 1'b0);
    push_beat(0, 1'b0);
    wait_drain();

    // Threshold 0: everything non-negative turns white, errors go far negative.
    write_reg(REG_LINE_WIDTH, 3);
    write_reg(REG_THRESHOLD, 0);
    @(negedge clk);
    push_beat(0, 1'b1);
    push_beat(255, 1'b0);
    push_beat(0, 1'b0);
    push_beat(0, 1'b0);
    push_beat(0, 1'b0);
    push_beat(0, 1'b0);
    wait_drain();

    // Threshold 255: only a fully corrected white stays white.
    write_reg(REG_THRESHOLD, 255);
    @(negedge clk);
    push_beat(255, 1'b1);
    push_beat(254, 1'b0);
    push_beat(255, 1'b0);
    push_beat(255, 1'b0);
    push_beat(255, 1'b0);
    push_beat(255, 1'b0);
    wait_drain();

    // Width past the line store: clipped, so no row end shows up here.
    write_reg(REG_LINE_WIDTH, 8191);
    write_reg(REG_THRESHOLD, 128);
    @(negedge clk);
    push_beat(128, 1'b1);
    push_beat(127, 1'b0);
    push_beat(1, 1'b0);
    push_beat(254, 1'b0);
    wait_drain();

    // Random phases; the first one shrinks the width in the middle of a row.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_LINE_WIDTH, phase_width[p]);
      write_reg(REG_THRESHOLD, phase_thresh[p]);
      random_phase(phase_items[p]);
    end

    // Let any stray result surface before the verdict.
    repeat (10) @(posedge clk);
    if (dither_expect_q.size() != 0)
      report_mismatch("results never delivered, count", 0, dither_expect_q.size());

    $display("Covered %0d pixel beats over %0d register writes: widths 0 to 8191, thresholds",
             sent_cnt, reg_writes);
    $display("0 to 255, mid-row shrink, stray frame starts; %0d results, %0d mismatches.",
             checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: a correct run ends far earlier than this.
  initial begin
    #10_000_000;
    $display("Timeout after %0d pixel beats and %0d results", sent_cnt, checked_cnt);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> error_diffusion_dither_core.f
hdl/efd_pkg.sv
hdl/efd_stream_if.sv
hdl/error_diffusion_dither_core.sv
sim/error_diffusion_dither_core_tb.sv
